### hdl/losc_pkg.sv
// Shared types and constants for the lock order stack checker.
// No dependencies; imported by losc_stack_mem and lock_order_stack_checker.
package losc_pkg;

    localparam int NUM_CPUS_DEF    = 4;
    localparam int MAX_NESTING_DEF = 16;

    localparam int MODE_W    = 2;
    localparam int CPU_W     = 4;
    localparam int RANK_W    = 8;
    localparam int LOCK_W    = 32;
    localparam int SITE_W    = 32;
    localparam int TASK_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_O_W = 5;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 96;

    localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVERSION = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LIFO  = 2'd3;

    // one held lock
    typedef struct packed {
        logic [LOCK_W-1:0]        lock;
        logic [SITE_W-1:0]        site;
        logic signed [TASK_W-1:0] task_id;
        logic [RANK_W-1:0]        rank;
    } entry_t;

endpackage

### hdl/losc_stack_mem.sv
// Held-lock entry memory: one write port, one registered read port.
// Depends on losc_pkg (entry_t). Same-edge write to the read address is bypassed.
module losc_stack_mem
    import losc_pkg::*;
#(
    parameter int DEPTH = NUM_CPUS_DEF * MAX_NESTING_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_q_reg;
    entry_t byp_reg;
    logic   byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            byp_reg     <= wr_data;
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_reg : rd_q_reg;

endmodule

### hdl/lock_order_stack_checker.sv
// Top level of the lock order stack checker: per-CPU held-lock stacks.
// Depends on losc_pkg and losc_stack_mem.
//
// Channel   Dir  Handshake         Contents
// s_*       in   tvalid/tready     one lock event (tuser: mode; tdata: cpu..task_id)
// m_*       out  tvalid/tready     one result per event (status, depth, top entry)
// cfg_*     in   write enable      ignored_rank
//
// One item per cycle while m_tready is high. m_tvalid rises once an accepted item has
// passed the input register, the registered top-entry read and the result register.
// Depth and the top entry are forwarded from the committing item, so events on
// the same CPU may follow back to back. Reset clears stage valids, stack depths
// and ignored_rank; the entry memory is not cleared. When m_tready is low the
// three stages fill and then s_tready drops.
module lock_order_stack_checker
    import losc_pkg::*;
#(
    parameter int NUM_CPUS    = NUM_CPUS_DEF,
    parameter int MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] mode
    input  logic [S_TUSER_W-1:0] s_tuser,
    // [3:0] cpu, [11:4] rank, [43:12] lock_id, [75:44] call_site,
    // [91:76] task_id, [95:92] zero
    input  logic [S_TDATA_W-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [6:2] depth_now, [7] top_valid, [15:8] top_rank,
    // [47:16] top_lock, [79:48] top_site, [95:80] top_task
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_wr_en,
    input  logic [RANK_W-1:0]    cfg_wr_data
);

    localparam int SW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int DW        = $clog2(MAX_NESTING + 1);
    localparam int MEM_DEPTH = NUM_CPUS * MAX_NESTING;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // ---------------- configuration ----------------
    logic [RANK_W-1:0] ignored_rank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignored_rank_reg <= '0;
        end else if (cfg_wr_en) begin
            ignored_rank_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage A: input register ----------------
    logic                     a_valid_reg;
    logic [MODE_W-1:0]        a_mode_reg;
    logic [CPU_W-1:0]         a_cpu_reg;
    logic [RANK_W-1:0]        a_rank_reg;
    logic [LOCK_W-1:0]        a_lock_reg;
    logic [SITE_W-1:0]        a_site_reg;
    logic signed [TASK_W-1:0] a_task_reg;

    // ---------------- stage B: top entry read back ----------------
    logic                     b_valid_reg;
    logic [MODE_W-1:0]        b_mode_reg;
    logic [SW-1:0]            b_sel_reg;
    logic [DW-1:0]            b_depth_reg;
    logic [RANK_W-1:0]        b_rank_reg;
    logic [LOCK_W-1:0]        b_lock_reg;
    logic [SITE_W-1:0]        b_site_reg;
    logic signed [TASK_W-1:0] b_task_reg;

    // ---------------- result register ----------------
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic [DW-1:0] depth_reg [NUM_CPUS];

    // flow control: every stage moves when the one after it frees up
    logic out_ready;
    logic a_adv;
    logic b_commit;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign a_adv     = !b_valid_reg || out_ready;
    assign s_tready  = !a_valid_reg || a_adv;
    assign b_commit  = b_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_mode_reg <= s_tuser[MODE_W-1:0];
            a_cpu_reg  <= s_tdata[3:0];
            a_rank_reg <= s_tdata[11:4];
            a_lock_reg <= s_tdata[43:12];
            a_site_reg <= s_tdata[75:44];
            a_task_reg <= s_tdata[91:76];
        end
    end

    // ---------------- stage A decode ----------------
    logic [SW-1:0] a_sel;
    logic [DW-1:0] a_depth;
    logic [AW-1:0] a_rd_addr;
    logic [DW-1:0] b_depth_new;

    // out-of-range CPU numbers fold onto stack 0
    assign a_sel = ({1'b0, a_cpu_reg} < (CPU_W+1)'(NUM_CPUS)) ? SW'(a_cpu_reg) : '0;

    // take the depth the committing item leaves behind on the same stack
    assign a_depth = (b_commit && (b_sel_reg == a_sel)) ? b_depth_new : depth_reg[a_sel];

    assign a_rd_addr = AW'(AW'(a_sel) * AW'(MAX_NESTING))
                     + ((a_depth == '0) ? '0 : AW'(a_depth - DW'(1)));

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_mode_reg  <= a_mode_reg;
            b_sel_reg   <= a_sel;
            b_depth_reg <= a_depth;
            b_rank_reg  <= a_rank_reg;
            b_lock_reg  <= a_lock_reg;
            b_site_reg  <= a_site_reg;
            b_task_reg  <= a_task_reg;
        end
    end

    // ---------------- entry memory ----------------
    entry_t        top_entry;
    entry_t        push_entry;
    logic          push;
    logic [AW-1:0] push_addr;

    assign push_entry = '{lock: b_lock_reg, site: b_site_reg,
                          task_id: b_task_reg, rank: b_rank_reg};
    assign push_addr  = AW'(AW'(b_sel_reg) * AW'(MAX_NESTING)) + AW'(b_depth_reg);

    losc_stack_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (b_commit && push),
        .wr_addr (push_addr),
        .wr_data (push_entry),
        .rd_en   (a_adv),
        .rd_addr (a_rd_addr),
        .rd_data (top_entry)
    );

    // ---------------- stage B: check ----------------
    logic                     has_top;
    logic [RANK_W-1:0]        t_rank;
    logic [LOCK_W-1:0]        t_lock;
    logic [SITE_W-1:0]        t_site;
    logic signed [TASK_W-1:0] t_task;
    logic [STATUS_W-1:0]      status;
    logic                     pop;
    logic                     skip;

    assign has_top = (b_depth_reg != '0);
    assign t_rank  = has_top ? top_entry.rank    : ignored_rank_reg;
    assign t_lock  = has_top ? top_entry.lock    : '0;
    assign t_site  = has_top ? top_entry.site    : '0;
    assign t_task  = has_top ? top_entry.task_id : '0;

    // untracked lock or reserved mode: answer ok, touch nothing
    assign skip = (b_rank_reg == ignored_rank_reg) || (b_mode_reg == MODE_RSVD);

    always_comb begin
        status = ST_OK;
        push   = 1'b0;
        pop    = 1'b0;
        priority if (skip) begin
            status = ST_OK;
        end else if (b_mode_reg == MODE_RELEASE) begin
            if (!has_top || (t_lock != b_lock_reg) || (t_rank != b_rank_reg)) begin
                status = ST_NOT_LIFO;
            end else begin
                pop = 1'b1;
            end
        end else if (b_depth_reg >= DW'(MAX_NESTING)) begin
            status = ST_OVERFLOW;
        end else if (has_top && (b_rank_reg <= t_rank)) begin
            status = ST_INVERSION;
        end else begin
            push = (b_mode_reg == MODE_ACQUIRE);
        end
    end

    always_comb begin
        b_depth_new = b_depth_reg;
        if (push) begin
            b_depth_new = b_depth_reg + DW'(1);
        end else if (pop) begin
            b_depth_new = b_depth_reg - DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                depth_reg[i] <= '0;
            end
        end else if (b_commit) begin
            depth_reg[b_sel_reg] <= b_depth_new;
        end
    end

    // ---------------- result register ----------------
    assign m_tdata_next = {t_task, t_site, t_lock, t_rank, has_top,
                           DEPTH_O_W'(b_depth_reg), status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (a_adv) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready) begin
                m_tvalid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
